[sv/pdvm_pkg.sv]
package pdvm_pkg;

   localparam int BLOCK_WORDS = 10;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_EXEC  = 2'd2;

   localparam logic [31:0] ZERO_WORD = 32'h3030_3030;
   localparam logic [31:0] WORD_HALT = 32'h4841_4C54;
   localparam logic [7:0]  CH_DASH   = 8'h2D;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;

   localparam logic [15:0] OP_AD = 16'h4144;
   localparam logic [15:0] OP_LR = 16'h4C52;
   localparam logic [15:0] OP_SR = 16'h5352;
   localparam logic [15:0] OP_CR = 16'h4352;
   localparam logic [15:0] OP_BT = 16'h4254;
   localparam logic [15:0] OP_PD = 16'h5044;

   typedef struct packed {
      logic [1:0]  command;
      logic [8:0]  address;
      logic [31:0] write_word;
   } req_type;

   typedef struct packed {
      logic [31:0] read_word;
      logic [31:0] register_word;
      logic        compare_flag;
      logic [6:0]  instruction_counter;
      logic        halted;
      logic        is_print;
      logic        last;
   } rsp_type;

   function automatic logic [7:0] digit_val(input logic [7:0] c);
      digit_val = c - CH_ZERO;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [19:0] word_value(input logic [31:0] w);
      word_value = 20'(digit_val(w[31:24])) * 20'd1000 + 20'(digit_val(w[23:16])) * 20'd100
                 + 20'(digit_val(w[15:8])) * 20'd10 + 20'(digit_val(w[7:0]));
   endfunction

endpackage

[sv/pdvm_cdiv.sv]
module pdvm_cdiv #(
   parameter int DIVISOR = 10,
   parameter int IN_W = 14
) (
   input  logic                         clock,
   input  logic [IN_W-1:0]              value,
   output logic [IN_W-1:0]              quot,
   output logic [$clog2(DIVISOR)-1:0]   rem
);
   // Reciprocal multiplication; the shift is wide enough that the quotient is exact.
   localparam int SH = IN_W + $clog2(DIVISOR) + 1;
   localparam int RW = IN_W + 3;
   localparam int DW = $clog2(DIVISOR + 1);
   localparam int RMW = $clog2(DIVISOR);
   localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RW-1:0] RECIP_C = RECIP[RW-1:0];
   localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);

   logic [IN_W+RW-1:0] prod;
   logic [IN_W+RW-1:0] prod_sh;
   logic [IN_W-1:0]    q_in;
   logic [IN_W-1:0]    q_ff;
   logic [IN_W-1:0]    v_ff;
   logic [IN_W+DW-1:0] qd;
   logic [IN_W+DW-1:0] diff;

   assign prod = {{RW{1'b0}}, value} * {{IN_W{1'b0}}, RECIP_C};
   assign prod_sh = prod >> SH;
   assign q_in = prod_sh[IN_W-1:0];

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      v_ff <= value;
   end

   assign qd = {{DW{1'b0}}, q_ff} * {{IN_W{1'b0}}, DIV_C};
   assign diff = {{DW{1'b0}}, v_ff} - qd;
   assign quot = q_ff;
   assign rem = diff[RMW-1:0];
endmodule

[sv/paged_decimal_vm_executor.sv]
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_type: command, address, write_word
// rsp     | out       | rsp_valid/rsp_stall | rsp_type: read_word .. last
// csr     | in        | csr_valid/csr_ready | page table block, 5 bits
//
// A write goes straight to its result and a read passes through the store's read port; an
// execute walks the page table and the word store through the one read port, again for an
// operand and for each word that PD prints; AD then turns its sum into digits one by one.
// Each address translation is two dependent reads plus two modulo steps. After reset the
// word store is cleared, one word a cycle; no item is accepted meanwhile. A stalled result
// holds; the next item may be taken while it waits.
module paged_decimal_vm_executor
   import pdvm_pkg::*;
#(
   parameter int MEMORY_WORDS = 300
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);
   localparam int AW = $clog2(MEMORY_WORDS);

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_READ  = 5'd2;
   localparam logic [4:0] S_EMIT  = 5'd3;
   localparam logic [4:0] S_FETCH = 5'd4;
   localparam logic [4:0] S_TE0   = 5'd5;
   localparam logic [4:0] S_TE1   = 5'd6;
   localparam logic [4:0] S_TE2   = 5'd7;
   localparam logic [4:0] S_TR0   = 5'd8;
   localparam logic [4:0] S_TR1   = 5'd9;
   localparam logic [4:0] S_TR2   = 5'd10;
   localparam logic [4:0] S_OP    = 5'd11;
   localparam logic [4:0] S_AD0   = 5'd12;
   localparam logic [4:0] S_AD1   = 5'd13;
   localparam logic [4:0] S_AD2   = 5'd14;
   localparam logic [4:0] S_AD3   = 5'd15;
   localparam logic [4:0] S_PD    = 5'd16;

   logic [31:0] mem [MEMORY_WORDS];
   logic [31:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;
   logic [31:0]   wdata;

   logic [4:0]    state_ff, state_in, ret_ff, ret_in;
   logic [AW-1:0] clr_ff, clr_in, ra_ff, ra_in;
   logic [4:0]    ptb_ff;
   logic [3:0]    hi_ff, hi_in, lo_ff, lo_in, tx1_ff, tx1_in, tx2_ff, tx2_in, k_ff, k_in;
   logic [31:0]   acc_ff, acc_in, ew_ff, ew_in;
   logic          cond_ff, cond_in, stop_ff, stop_in;
   logic [14:0]   x_ff, x_in;
   logic [15:0]   op_ff, op_in;
   logic [19:0]   sum_ff, sum_in;
   logic [13:0]   dec_ff, dec_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          print_ff, print_in, last_ff, last_in, rdok_ff, rdok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [AW-1:0] modm_rem;
   logic [14:0]   modm_quot;
   logic [13:0]   m10k_rem;
   logic [19:0]   m10k_quot;
   logic [3:0]    d10_rem;
   logic [13:0]   d10_quot;

   logic out_free;
   logic req_take;
   logic [3:0] hi_next, lo_next;

   pdvm_cdiv #(.DIVISOR(MEMORY_WORDS), .IN_W(15)) u_modm (
      .clock(clock), .value(x_ff), .quot(modm_quot), .rem(modm_rem));
   pdvm_cdiv #(.DIVISOR(10000), .IN_W(20)) u_mod10k (
      .clock(clock), .value(sum_ff), .quot(m10k_quot), .rem(m10k_rem));
   pdvm_cdiv #(.DIVISOR(10), .IN_W(14)) u_div10 (
      .clock(clock), .value(dec_ff), .quot(d10_quot), .rem(d10_rem));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      if (lo_ff == 4'd9) begin
         lo_next = 4'd0;
         hi_next = (hi_ff == 4'd9) ? 4'd0 : hi_ff + 4'd1;
      end else begin
         lo_next = lo_ff + 4'd1;
         hi_next = hi_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      clr_in = clr_ff;
      ra_in = ra_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      tx1_in = tx1_ff;
      tx2_in = tx2_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      ew_in = ew_ff;
      cond_in = cond_ff;
      stop_in = stop_ff;
      x_in = x_ff;
      op_in = op_ff;
      sum_in = sum_ff;
      dec_in = dec_ff;
      cnt_in = cnt_ff;
      print_in = print_ff;
      last_in = last_ff;
      rdok_in = rdok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      waddr = clr_ff;
      wdata = ZERO_WORD;
      raddr = ra_ff;

      case (state_ff)
         S_CLR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MEMORY_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            raddr = AW'(req_payload.address);
            if (req_take) begin
               ew_in = '0;
               print_in = 1'b0;
               last_in = 1'b1;
               state_in = S_EMIT;
               if (req_payload.command == CMD_WRITE) begin
                  if (32'(req_payload.address) < MEMORY_WORDS) begin
                     mem_we = 1'b1;
                     waddr = AW'(req_payload.address);
                     wdata = req_payload.write_word;
                  end
               end else if (req_payload.command == CMD_READ) begin
                  rdok_in = 32'(req_payload.address) < MEMORY_WORDS;
                  state_in = S_READ;
               end else if (req_payload.command == CMD_EXEC && !stop_ff) begin
                  tx1_in = hi_ff;
                  tx2_in = lo_ff;
                  ret_in = S_FETCH;
                  state_in = S_TE0;
               end
            end
         end
         S_READ: begin
            ew_in = rdok_ff ? rdata_ff : '0;
            state_in = S_EMIT;
         end
         // Translation: page table entry, then the real word, each reduced modulo the size.
         S_TE0: begin
            x_in = 15'(ptb_ff) * 15'(BLOCK_WORDS) + 15'(tx1_ff);
            state_in = S_TE1;
         end
         S_TE1: state_in = S_TE2;
         S_TE2: begin
            raddr = modm_rem;
            state_in = S_TR0;
         end
         S_TR0: begin
            x_in = 15'(digit_val(rdata_ff[31:24])) * 15'd100
                 + 15'(digit_val(rdata_ff[23:16])) * 15'd10 + 15'(tx2_ff);
            state_in = S_TR1;
         end
         S_TR1: state_in = S_TR2;
         S_TR2: begin
            ra_in = modm_rem;
            raddr = modm_rem;
            state_in = ret_ff;
         end
         S_FETCH: begin
            op_in = rdata_ff[31:16];
            state_in = S_EMIT;
            if (rdata_ff[31:24] == CH_DASH && rdata_ff[23:16] == CH_DASH) begin
               hi_in = (hi_ff == 4'd9) ? 4'd0 : hi_ff + 4'd1;
               lo_in = 4'd0;
            end else begin
               hi_in = hi_next;
               lo_in = lo_next;
               if (rdata_ff == WORD_HALT) begin
                  stop_in = 1'b1;
               end else if (is_digit(rdata_ff[15:8]) && is_digit(rdata_ff[7:0])) begin
                  tx1_in = rdata_ff[11:8];
                  tx2_in = rdata_ff[3:0];
                  if (rdata_ff[31:16] == OP_BT) begin
                     if (cond_ff) begin
                        hi_in = rdata_ff[11:8];
                        lo_in = rdata_ff[3:0];
                     end
                  end else if (rdata_ff[31:16] == OP_PD) begin
                     k_in = 4'd0;
                     tx2_in = 4'd0;
                     ret_in = S_PD;
                     state_in = S_TE0;
                  end else if (rdata_ff[31:16] == OP_AD || rdata_ff[31:16] == OP_LR
                               || rdata_ff[31:16] == OP_SR || rdata_ff[31:16] == OP_CR) begin
                     ret_in = S_OP;
                     state_in = S_TE0;
                  end
               end
            end
         end
         S_OP: begin
            state_in = S_EMIT;
            if (op_ff == OP_LR) begin
               acc_in = rdata_ff;
            end else if (op_ff == OP_SR) begin
               mem_we = 1'b1;
               waddr = ra_ff;
               wdata = acc_ff;
            end else if (op_ff == OP_CR) begin
               cond_in = (rdata_ff == acc_ff);
            end else if (op_ff == OP_AD) begin
               sum_in = word_value(acc_ff) + word_value(rdata_ff);
               state_in = S_AD0;
            end
         end
         S_AD0: state_in = S_AD1;
         S_AD1: begin
            dec_in = m10k_rem;
            cnt_in = 2'd0;
            state_in = S_AD2;
         end
         S_AD2: state_in = S_AD3;
         // Units digit first; each new digit enters at the top and shifts the rest down.
         S_AD3: begin
            acc_in = {CH_ZERO + 8'(d10_rem), acc_ff[31:8]};
            dec_in = d10_quot;
            cnt_in = cnt_ff + 2'd1;
            state_in = (cnt_ff == 2'd3) ? S_EMIT : S_AD2;
         end
         S_PD: begin
            ew_in = rdata_ff;
            print_in = 1'b1;
            last_in = (k_ff == 4'd9);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.read_word = ew_ff;
               rsp_data_in.register_word = acc_ff;
               rsp_data_in.compare_flag = cond_ff;
               rsp_data_in.instruction_counter = 7'(hi_ff) * 7'd10 + 7'(lo_ff);
               rsp_data_in.halted = stop_ff;
               rsp_data_in.is_print = print_ff;
               rsp_data_in.last = last_ff;
               if (last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 4'd1;
                  tx2_in = k_ff + 4'd1;
                  ret_in = S_PD;
                  state_in = S_TE0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         ret_ff <= S_IDLE;
         clr_ff <= '0;
         ptb_ff <= '0;
         hi_ff <= '0;
         lo_ff <= '0;
         acc_ff <= ZERO_WORD;
         cond_ff <= 1'b0;
         stop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         clr_ff <= clr_in;
         if (csr_valid && csr_ready) begin
            ptb_ff <= csr_data;
         end
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         acc_ff <= acc_in;
         cond_ff <= cond_in;
         stop_ff <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff <= ra_in;
      tx1_ff <= tx1_in;
      tx2_ff <= tx2_in;
      k_ff <= k_in;
      ew_ff <= ew_in;
      x_ff <= x_in;
      op_ff <= op_in;
      sum_ff <= sum_in;
      dec_ff <= dec_in;
      cnt_ff <= cnt_in;
      print_ff <= print_in;
      last_ff <= last_in;
      rdok_ff <= rdok_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

[sv/pdvm_checker.sv]
module pdvm_checker
   import pdvm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input req_type    req_payload,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input rsp_type    rsp_payload,
   input logic       csr_valid,
   input logic       csr_ready,
   input logic [4:0] csr_data
);
   // A stalled result item must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

   // The store is being cleared straight after reset, so no item may be taken.
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken during the clearing pass");

   // Only printed words come in groups; every other item gives one result.
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.is_print |-> rsp_payload.last)
      else $error("non-print result without last");

   a_counter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.instruction_counter <= 7'd99)
      else $error("instruction counter beyond 99");
endmodule

bind paged_decimal_vm_executor pdvm_checker u_pdvm_checker (.*);

[tb/sv/tb_paged_decimal_vm_executor.sv]
`timescale 1ns / 1ps

module tb_paged_decimal_vm_executor;
   import pdvm_pkg::*;

   localparam int MEM_WORDS = 300;
   localparam int QUIET_LIMIT = 20000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_data = '0;

   paged_decimal_vm_executor #(.MEMORY_WORDS(MEM_WORDS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Machine state as the executor should hold it.
   logic [31:0] mem_words [MEM_WORDS];
   logic [31:0] acc_word;
   logic        cond_flag;
   logic [6:0]  instr_ctr;
   logic        stop_flag;
   logic [4:0]  table_block;

   rsp_type expected_rsps [$];
   int      error_count = 0;
   int      quiet_cycles = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_off = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [7:0] char_val(input logic [7:0] c);
      return c - 8'h30;
   endfunction

   function automatic int real_address(input int blk, input int ofs);
      int          entry;
      logic [31:0] e;
      entry = (int'(table_block) * BLOCK_WORDS + blk) % MEM_WORDS;
      e = mem_words[entry];
      return (int'(char_val(e[31:24])) * 100 + int'(char_val(e[23:16])) * 10 + ofs)
             % MEM_WORDS;
   endfunction

   function automatic int decimal_of(input logic [31:0] w);
      return int'(char_val(w[31:24])) * 1000 + int'(char_val(w[23:16])) * 100
           + int'(char_val(w[15:8])) * 10 + int'(char_val(w[7:0]));
   endfunction

   function automatic void push_state(input logic [31:0] word, input logic prn,
                                      input logic lst);
      rsp_type r;
      r.read_word = word;
      r.register_word = acc_word;
      r.compare_flag = cond_flag;
      r.instruction_counter = instr_ctr;
      r.halted = stop_flag;
      r.is_print = prn;
      r.last = lst;
      expected_rsps.push_back(r);
   endfunction

   function automatic void predict_item(input req_type q);
      int          pc, blk, ofs, ra, s;
      logic [31:0] ins;
      logic [15:0] op;
      if (q.command == CMD_WRITE) begin
         if (q.address < MEM_WORDS) mem_words[q.address] = q.write_word;
         push_state('0, 1'b0, 1'b1);
         return;
      end
      if (q.command == CMD_READ) begin
         push_state(q.address < MEM_WORDS ? mem_words[q.address] : 32'h0, 1'b0, 1'b1);
         return;
      end
      if (q.command == CMD_EXEC && !stop_flag) begin
         pc = int'(instr_ctr) % 100;
         ins = mem_words[real_address(pc / 10, pc % 10)];
         op = ins[31:16];
         if (ins[31:24] == CH_DASH && ins[23:16] == CH_DASH) begin
            instr_ctr = 7'(((pc / 10 + 1) * 10) % 100);
         end else begin
            instr_ctr = 7'((pc + 1) % 100);
            if (ins == WORD_HALT) begin
               stop_flag = 1'b1;
            end else if (ins[15:8] >= CH_ZERO && ins[15:8] <= CH_NINE &&
                         ins[7:0] >= CH_ZERO && ins[7:0] <= CH_NINE) begin
               blk = ins[15:8] - 8'h30;
               ofs = ins[7:0] - 8'h30;
               ra = real_address(blk, ofs);
               case (op)
                  OP_PD: begin
                     for (int k = 0; k < 10; k++)
                        push_state(mem_words[real_address(blk, k)], 1'b1, k == 9);
                     return;
                  end
                  OP_AD: begin
                     s = (decimal_of(acc_word) + decimal_of(mem_words[ra])) % 10000;
                     acc_word = {8'(s / 1000 + 48), 8'(s / 100 % 10 + 48),
                                 8'(s / 10 % 10 + 48), 8'(s % 10 + 48)};
                  end
                  OP_LR: acc_word = mem_words[ra];
                  OP_SR: mem_words[ra] = acc_word;
                  OP_CR: cond_flag = (mem_words[ra] == acc_word);
                  OP_BT: if (cond_flag) instr_ctr = 7'(blk * 10 + ofs);
                  default: ;
               endcase
            end
         end
      end
      push_state('0, 1'b0, 1'b1);
   endfunction

   // Result checker and receiver stalls.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", rsp_payload.read_word, '0);
         end else begin
            w = expected_rsps.pop_front();
            if (rsp_payload.read_word !== w.read_word)
               report_mismatch("read_word", rsp_payload.read_word, w.read_word);
            if (rsp_payload.register_word !== w.register_word)
               report_mismatch("register_word", rsp_payload.register_word, w.register_word);
            if (rsp_payload.compare_flag !== w.compare_flag)
               report_mismatch("compare_flag", 32'(rsp_payload.compare_flag),
                               32'(w.compare_flag));
            if (rsp_payload.instruction_counter !== w.instruction_counter)
               report_mismatch("instruction_counter", 32'(rsp_payload.instruction_counter),
                               32'(w.instruction_counter));
            if (rsp_payload.halted !== w.halted)
               report_mismatch("halted", 32'(rsp_payload.halted), 32'(w.halted));
            if (rsp_payload.is_print !== w.is_print)
               report_mismatch("is_print", 32'(rsp_payload.is_print), 32'(w.is_print));
            if (rsp_payload.last !== w.last)
               report_mismatch("last", 32'(rsp_payload.last), 32'(w.last));
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

   // Watchdog on cycles with no accepted item of any kind; the clearing pass is short.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("paged_decimal_vm_executor verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic [8:0] addr,
                            input logic [31:0] data);
      req_type q;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      q.command = cmd;
      q.address = addr;
      q.write_word = data;
      req_valid = 1'b1;
      req_payload = q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(q);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drain();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_table_block(input logic [4:0] blk);
      wait_drain();
      csr_valid <= 1'b1;
      csr_data <= blk;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      table_block = blk;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Page table maps virtual block v to real block base+v (two ASCII digits).
   task automatic load_page_table(input int pt, input int base);
      for (int v = 0; v < 10; v++)
         send_item(CMD_WRITE, 9'(pt * 10 + v),
                   {8'((base + v) / 10 + 48), 8'((base + v) % 10 + 48), 16'h3030});
   endtask

   function automatic logic [31:0] make_ins(input logic [15:0] op, input int opnd);
      return {op, 8'(opnd / 10 + 48), 8'(opnd % 10 + 48)};
   endfunction

   task automatic test_directed();
      send_item(CMD_READ, 9'd0, '0);
      send_item(CMD_WRITE, 9'd299, 32'hFFFF_FFFF);
      send_item(CMD_READ, 9'd299, '0);
      send_item(CMD_WRITE, 9'd511, 32'h1234_5678);
      send_item(CMD_READ, 9'd300, '0);
      send_item(2'd3, 9'd0, '0);
      // Program in real block 1 with page table at block 0 pointing at 1..10.
      load_page_table(0, 1);
      send_item(CMD_WRITE, 9'd30, 32'h3132_3334);
      send_item(CMD_WRITE, 9'd10, make_ins(OP_LR, 20));
      send_item(CMD_WRITE, 9'd11, make_ins(OP_AD, 20));
      send_item(CMD_WRITE, 9'd12, make_ins(OP_SR, 21));
      send_item(CMD_WRITE, 9'd13, make_ins(OP_CR, 21));
      send_item(CMD_WRITE, 9'd14, make_ins(OP_BT, 16));
      send_item(CMD_WRITE, 9'd16, make_ins(OP_PD, 20));
      send_item(CMD_WRITE, 9'd17, 32'h2D2D_3030);
      send_item(CMD_WRITE, 9'd20, WORD_HALT);
      for (int k = 0; k < 9; k++) send_item(CMD_EXEC, '0, '0);
   endtask

   task automatic test_random(input int count);
      int r;
      logic [15:0] ops [7] = '{OP_AD, OP_LR, OP_SR, OP_CR, OP_BT, OP_PD, 16'h2D2D};
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 30)
            send_item(CMD_EXEC, 9'($urandom), $urandom);
         else if (r < 55)
            send_item(CMD_WRITE, 9'($urandom_range(10, 109)),
                      make_ins(ops[$urandom_range(6)], $urandom_range(99)));
         else if (r < 65)
            send_item(CMD_WRITE, 9'($urandom_range(10, 109)), $urandom);
         else if (r < 72)
            send_item(CMD_WRITE, 9'($urandom), $urandom);
         else if (r < 74)
            send_item(CMD_WRITE, 9'($urandom_range(10, 109)), WORD_HALT);
         else if (r < 92)
            send_item(CMD_READ, 9'($urandom), '0);
         else
            send_item(2'($urandom), 9'($urandom), $urandom);
      end
   endtask

   task automatic test_fill_stall();
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int n = 0; n < 12; n++) send_item(CMD_READ, 9'($urandom_range(299)), '0);
      join
      wait_drain();
   endtask

   task automatic test_table_moves();
      // Full-width register values and a table that leaves the program area.
      write_table_block(5'd31);
      test_random(10);
      write_table_block(5'd29);
      load_page_table(29, 20);
      test_random(10);
      write_table_block(5'd0);
   endtask

   initial begin
      foreach (mem_words[i]) mem_words[i] = ZERO_WORD;
      acc_word = ZERO_WORD;
      cond_flag = 1'b0;
      instr_ctr = '0;
      stop_flag = 1'b0;
      table_block = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      write_table_block(5'd0);
      send_idle_pct = 11;
      recv_idle_pct = 52;
      test_directed();
      test_fill_stall();
      test_random(15);
      test_table_moves();
      send_idle_pct = 52;
      recv_idle_pct = 11;
      test_random(15);
      wait_drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(15);
      wait_drain();
      if (error_count == 0)
         $display("paged_decimal_vm_executor verification clean");
      else
         $display("paged_decimal_vm_executor verification failed");
      $finish;
   end

endmodule
